### rtl/olm_pkg.sv
// Package for the ordered list move unit: field widths, list size,
// status and command codes, controller state and command types.
// No dependencies.
package olm_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // fixed field widths
  localparam int CMD_W  = 1;
  localparam int ID_W   = 7;
  localparam int OFF_W  = 7;
  localparam int RP_W   = 6;
  localparam int RPOS_W = 6;
  localparam int ST_W   = 2;
  localparam int CFG_W  = 7;

  localparam int TGT_W = ((IDX_W > OFF_W) ? IDX_W : OFF_W) + 2;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

  localparam logic [CMD_W-1:0] CMD_MOVE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_CLAMPED   = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } olm_state_t;

  typedef struct packed {
    logic capture;  // latch the input word
    logic search;   // compare all positions, read the addressed one
    logic commit;   // shift the list, load the result register
  } olm_cmd_t;

endpackage

### rtl/olm_if.sv
// Channel interfaces of the ordered list move unit: command in, result
// out, configuration write. Depends on olm_pkg.
interface olm_in_if;
  logic                             valid;
  logic                             ready;
  logic [olm_pkg::CMD_W-1:0]        cmd;
  logic [olm_pkg::ID_W-1:0]         entry_id;
  logic signed [olm_pkg::OFF_W-1:0] offset;
  logic [olm_pkg::RP_W-1:0]         read_position;

  modport source (output valid, cmd, entry_id, offset, read_position, input ready);
  modport sink (input valid, cmd, entry_id, offset, read_position, output ready);
endinterface

interface olm_out_if;
  logic                       valid;
  logic                       ready;
  logic [olm_pkg::ID_W-1:0]   result_id;
  logic [olm_pkg::RPOS_W-1:0] result_position;
  logic [olm_pkg::ST_W-1:0]   status;

  modport source (output valid, result_id, result_position, status, input ready);
  modport sink (input valid, result_id, result_position, status, output ready);
endinterface

interface olm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [olm_pkg::CFG_W-1:0] entries_in_use;

  modport source (output valid, entries_in_use, input ready);
  modport sink (input valid, entries_in_use, output ready);
endinterface

### rtl/ordered_list_move_by_offset_unit.sv
// Ordered list move unit, top level. Depends on olm_pkg, olm_if, olm_ctrl, olm_dp.
// Sequence: an accepted command word is captured, compared, then shifted and
//   committed; the commit waits only while the result word is held back.
// Commands: one at a time; the next word is taken only once the three-state
//   sequencer, which owns the list registers for the whole command, is back in idle.
// Reset (rst_n, synchronous): list holds ids 1..MAX_ENTRIES in order,
//   entries_in_use = 64, no result pending. No clearing pass.
module ordered_list_move_by_offset_unit (
  input  logic      clk,
  input  logic      rst_n,
  olm_in_if.sink    in_ch,
  olm_out_if.source out_ch,
  olm_cfg_if.sink   cfg_ch
);
  import olm_pkg::*;

  olm_cmd_t cmd;

  // Controller: one command in flight; the result register lets a new
  // command come in while the previous result word still waits.
  olm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Datapath: the list lives in a row of registers, one per position.
  // Search compares every position at once; the move shifts the segment
  // between old and new position by one place in a single update.
  olm_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg_we              (cfg_ch.valid),
    .cfg_entries_in_use  (cfg_ch.entries_in_use),
    .in_cmd              (in_ch.cmd),
    .in_entry_id         (in_ch.entry_id),
    .in_offset           (in_ch.offset),
    .in_read_position    (in_ch.read_position),
    .out_result_id       (out_ch.result_id),
    .out_result_position (out_ch.result_position),
    .out_status          (out_ch.status)
  );

  // configuration word is always taken
  assign cfg_ch.ready = 1'b1;

endmodule

### rtl/olm_ctrl.sv
// Controller of the ordered list move unit: sequences capture, search and
// commit, and owns the channel handshakes. Depends on olm_pkg.
module olm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output olm_pkg::olm_cmd_t cmd
);
  import olm_pkg::*;

  olm_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        // wait for the result slot to free up
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/olm_dp.sv
// Datapath of the ordered list move unit: list registers, parallel id
// compare, target clamp, segment shift and result register. Depends on olm_pkg.
module olm_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  olm_pkg::olm_cmd_t                cmd,
  input  logic                             cfg_we,
  input  logic [olm_pkg::CFG_W-1:0]        cfg_entries_in_use,
  input  logic [olm_pkg::CMD_W-1:0]        in_cmd,
  input  logic [olm_pkg::ID_W-1:0]         in_entry_id,
  input  logic signed [olm_pkg::OFF_W-1:0] in_offset,
  input  logic [olm_pkg::RP_W-1:0]         in_read_position,
  output logic [olm_pkg::ID_W-1:0]         out_result_id,
  output logic [olm_pkg::RPOS_W-1:0]       out_result_position,
  output logic [olm_pkg::ST_W-1:0]         out_status
);
  import olm_pkg::*;

  logic [CFG_W-1:0]        cfg_r;
  logic [CNT_W-1:0]        act_n;

  logic [CMD_W-1:0]        cmd_r;
  logic [CNT_W-1:0]        id_r;
  logic signed [OFF_W-1:0] off_r;
  logic [RP_W-1:0]         rp_r;

  logic [CNT_W-1:0]        list_r [MAX_ENTRIES];
  logic [CNT_W-1:0]        list_nxt [MAX_ENTRIES];
  logic [CNT_W-1:0]        up_nb [MAX_ENTRIES];
  logic [CNT_W-1:0]        dn_nb [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0]  match_r;
  logic [CNT_W-1:0]        rd_id_r;
  logic                    rd_nf_r;

  logic                    found;
  logic [IDX_W-1:0]        y;
  logic signed [TGT_W-1:0] t_raw;
  logic signed [TGT_W-1:0] n_last;
  logic [IDX_W-1:0]        t;
  logic                    clamped;
  logic                    fwd, bwd, do_move;

  logic [ID_W-1:0]         res_id_r, res_id_nxt;
  logic [RPOS_W-1:0]       res_pos_r, res_pos_nxt;
  logic [ST_W-1:0]         res_st_r, res_st_nxt;

  // register value of zero acts as one, above the table acts as full
  always_comb begin
    if (cfg_r == '0) begin
      act_n = CNT_W'(1);
    end else if (32'(cfg_r) > MAX_ENTRIES) begin
      act_n = CNT_W'(MAX_ENTRIES);
    end else begin
      act_n = CNT_W'(cfg_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      cfg_r <= cfg_entries_in_use;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= in_cmd;
      id_r  <= CNT_W'(in_entry_id);
      off_r <= in_offset;
      rp_r  <= in_read_position;
    end
  end

  // search: one comparator per position
  always_ff @(posedge clk) begin
    if (cmd.search) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        match_r[i] <= (list_r[i] == id_r) && (i < int'(act_n));
      end
      if (32'(rp_r) >= MAX_ENTRIES) begin
        rd_id_r <= '0;
        rd_nf_r <= 1'b1;
      end else begin
        rd_id_r <= list_r[IDX_W'(rp_r)];
        rd_nf_r <= 1'b0;
      end
    end
  end

  // lowest matching position
  always_comb begin
    y = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        y = IDX_W'(i);
      end
    end
  end
  assign found = |match_r;

  // target position, clamped to the used part
  assign t_raw  = $signed(TGT_W'(y)) + TGT_W'(off_r);
  assign n_last = $signed(TGT_W'(act_n)) - TGT_W'(1);

  always_comb begin
    clamped = 1'b0;
    t       = IDX_W'(t_raw);
    if (t_raw < 0) begin
      clamped = 1'b1;
      t       = '0;
    end else if (t_raw > n_last) begin
      clamped = 1'b1;
      t       = IDX_W'(n_last);
    end
  end

  assign fwd     = t > y;
  assign bwd     = t < y;
  assign do_move = cmd.commit && (cmd_r == CMD_MOVE) && found;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_nb
    if (g < MAX_ENTRIES - 1) begin : g_up
      assign up_nb[g] = list_r[g + 1];
    end else begin : g_up_end
      assign up_nb[g] = list_r[g];
    end
    if (g > 0) begin : g_dn
      assign dn_nb[g] = list_r[g - 1];
    end else begin : g_dn_end
      assign dn_nb[g] = list_r[g];
    end
  end

  // each position picks itself, its upper or lower neighbour, or the moved id
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      list_nxt[i] = list_r[i];
      if (IDX_W'(i) == t) begin
        list_nxt[i] = id_r;
      end else if (fwd && IDX_W'(i) >= y && IDX_W'(i) < t) begin
        list_nxt[i] = up_nb[i];
      end else if (bwd && IDX_W'(i) > t && IDX_W'(i) <= y) begin
        list_nxt[i] = dn_nb[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        list_r[i] <= CNT_W'(i + 1);
      end
    end else if (do_move) begin
      list_r <= list_nxt;
    end
  end

  always_comb begin
    if (cmd_r == CMD_READ) begin
      res_id_nxt  = ID_W'(rd_id_r);
      res_pos_nxt = RPOS_W'(rp_r);
      res_st_nxt  = rd_nf_r ? ST_NOT_FOUND : ST_OK;
    end else if (!found) begin
      res_id_nxt  = ID_W'(id_r);
      res_pos_nxt = '0;
      res_st_nxt  = ST_NOT_FOUND;
    end else begin
      res_id_nxt  = ID_W'(id_r);
      res_pos_nxt = RPOS_W'(t);
      res_st_nxt  = clamped ? ST_CLAMPED : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_id_r  <= res_id_nxt;
      res_pos_r <= res_pos_nxt;
      res_st_r  <= res_st_nxt;
    end
  end

  assign out_result_id       = res_id_r;
  assign out_result_position = res_pos_r;
  assign out_status          = res_st_r;

endmodule

### rtl/olm_chk.sv
// Port-level checker for the ordered list move unit, with its bind.
// Depends on olm_pkg and the top level ordered_list_move_by_offset_unit.
module olm_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [olm_pkg::ID_W-1:0]    out_id,
  input logic [olm_pkg::RPOS_W-1:0]  out_pos,
  input logic [olm_pkg::ST_W-1:0]    out_st
);
  import olm_pkg::*;

  // held result word does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_id) && $stable(out_pos)
      && $stable(out_st))
    else $error("result word changed while stalled");

  // one command at a time: not ready in the search and finish states after a word is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("command word taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_st == ST_OK || out_st == ST_NOT_FOUND || out_st == ST_CLAMPED))
    else $error("undefined status code");

  // a clamped move always names a real id
  a_clamp_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_st == ST_CLAMPED |-> out_id != '0)
    else $error("clamped move with null id");

endmodule

bind ordered_list_move_by_offset_unit olm_chk u_olm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_id    (out_ch.result_id),
  .out_pos   (out_ch.result_position),
  .out_st    (out_ch.status)
);
